// ===== src/ttlpq_pkg.sv =====
// Shared types and codes for the expiring descriptor queue.
package ttlpq_pkg;

   localparam logic [3:0] OP_ENQ       = 4'd0;
   localparam logic [3:0] OP_PUSH      = 4'd1;
   localparam logic [3:0] OP_DEQ_HEAD  = 4'd2;
   localparam logic [3:0] OP_DEQ_ADDR  = 4'd3;
   localparam logic [3:0] OP_DEQ_CHAN  = 4'd4;
   localparam logic [3:0] OP_DEQ_BOTH  = 4'd5;
   localparam logic [3:0] OP_DEQ_NCHAN = 4'd6;
   localparam logic [3:0] OP_COUNT     = 4'd7;
   localparam logic [3:0] OP_FIND      = 4'd8;
   localparam logic [3:0] OP_REMOVE    = 4'd9;
   localparam logic [3:0] OP_PURGE     = 4'd10;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   localparam logic [1:0] CSR_MAX_DELAY    = 2'd0;
   localparam logic [1:0] CSR_EVICT_OLDEST = 2'd1;
   localparam logic [1:0] CSR_MAX_PACKETS  = 2'd2;

   localparam logic [1:0] PASS_SEARCH  = 2'd0;
   localparam logic [1:0] PASS_COMPACT = 2'd1;
   localparam logic [1:0] PASS_SHIFT   = 2'd2;

   localparam int OUT_CNT_W = 10;

   typedef struct packed {
      logic       load;
      logic       pass_start;
      logic [1:0] pass_kind;
      logic       write_new;
      logic       finish;
      logic       drop;
   } cmd_type;

   typedef struct packed {
      logic pass_busy;
      logic hit_valid;
      logic full;
   } sts_type;

endpackage

// ===== src/ttlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttlpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/ttlpq_ctrl.sv =====
// Sequencer for the queue: chooses and orders the scan passes of each command.
module ttlpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [3:0]         req_opcode,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  ttlpq_pkg::sts_type sts,
   output ttlpq_pkg::cmd_type cmd
);
   import ttlpq_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECIDE  = 3'd1;
   localparam logic [2:0] S_SEARCH  = 3'd2;
   localparam logic [2:0] S_COMPACT = 3'd3;
   localparam logic [2:0] S_CHECK   = 3'd4;
   localparam logic [2:0] S_SHIFT   = 3'd5;
   localparam logic [2:0] S_WRITE   = 3'd6;
   localparam logic [2:0] S_RESP    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic       is_ins;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign is_ins    = (op_ff inside {OP_ENQ, OP_PUSH});

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (op_ff) inside
               OP_ENQ, OP_PUSH: begin
                  if (sts.full) begin
                     cmd.pass_start = 1'b1;
                     cmd.pass_kind  = PASS_SEARCH;
                     state_in       = S_SEARCH;
                  end else if (op_ff == OP_ENQ) begin
                     state_in = S_WRITE;
                  end else begin
                     cmd.pass_start = 1'b1;
                     cmd.pass_kind  = PASS_SHIFT;
                     state_in       = S_SHIFT;
                  end
               end
               [OP_DEQ_ADDR:OP_DEQ_NCHAN]: begin
                  cmd.pass_start = 1'b1;
                  cmd.pass_kind  = PASS_SEARCH;
                  state_in       = S_SEARCH;
               end
               OP_DEQ_HEAD, [OP_COUNT:OP_PURGE]: begin
                  cmd.pass_start = 1'b1;
                  cmd.pass_kind  = PASS_COMPACT;
                  state_in       = S_COMPACT;
               end
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = S_RESP;
               end
            endcase
         end
         S_SEARCH: begin
            if (!sts.pass_busy) begin
               if (sts.hit_valid) begin
                  cmd.pass_start = 1'b1;
                  cmd.pass_kind  = PASS_COMPACT;
                  state_in       = S_COMPACT;
               end else if (is_ins) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_RESP;
               end
            end
         end
         S_COMPACT: begin
            if (!sts.pass_busy) begin
               if (is_ins) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_RESP;
               end
            end
         end
         S_CHECK: begin
            if (sts.full) begin
               cmd.finish = 1'b1;
               cmd.drop   = 1'b1;
               state_in   = S_RESP;
            end else if (op_ff == OP_ENQ) begin
               state_in = S_WRITE;
            end else begin
               cmd.pass_start = 1'b1;
               cmd.pass_kind  = PASS_SHIFT;
               state_in       = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (!sts.pass_busy) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write_new = 1'b1;
            cmd.finish    = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_ENQ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

// ===== src/ttlpq_dp.sv =====
// Queue datapath: entry memory, scan pipeline, expiry test and result registers.
module ttlpq_dp #(
   parameter int QUEUE_DEPTH   = 512,
   parameter int CHANNEL_WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ttlpq_pkg::cmd_type       cmd,
   output ttlpq_pkg::sts_type       sts,
   input  logic [31:0]              max_delay,
   input  logic                     evict_oldest,
   input  logic [9:0]               max_packets,
   input  logic [3:0]               req_opcode,
   input  logic [47:0]              req_now_time,
   input  logic [47:0]              req_dest_addr,
   input  logic [CHANNEL_WIDTH-1:0] req_channel_id,
   input  logic                     req_is_data,
   input  logic [15:0]              req_packet_tag,
   input  logic [15:0]              req_packet_bytes,
   output logic [1:0]               rsp_status,
   output logic [15:0]              rsp_out_tag,
   output logic [47:0]              rsp_out_addr,
   output logic [CHANNEL_WIDTH-1:0] rsp_out_channel,
   output logic [15:0]              rsp_out_bytes,
   output logic [9:0]               rsp_out_count,
   output logic [9:0]               rsp_expired_removed
);
   import ttlpq_pkg::*;

   localparam int IW   = $clog2(QUEUE_DEPTH);
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = CW + 10;
   localparam int EW   = 48 + 48 + CHANNEL_WIDTH + 1 + 16 + 16;
   localparam int T_LO = 16;
   localparam int D_AT = 32;
   localparam int C_LO = 33;
   localparam int A_LO = C_LO + CHANNEL_WIDTH;
   localparam int M_LO = A_LO + 48;

   // latched command
   logic [3:0]               op_ff;
   logic [47:0]              now_ff, addr_ff;
   logic [CHANNEL_WIDTH-1:0] ch_ff;
   logic                     data_ff;
   logic [15:0]              tag_ff, bytes_ff;

   // pass engine
   logic [1:0]    kind_ff;
   logic [CW-1:0] len_ff, iss_ff, w_ff, live_ff, rd_idx;
   logic          v1_ff;
   logic [IW-1:0] idx1_ff, hit_ff;
   logic          found_ff, done_ff;
   logic [CW-1:0] removed_ff, count_ff;
   logic [1:0]    status_ff;
   logic [15:0]              rep_tag_ff, rep_bytes_ff;
   logic [47:0]              rep_addr_ff;
   logic [CHANNEL_WIDTH-1:0] rep_ch_ff;

   // memory port
   logic          we;
   logic [IW-1:0] waddr, raddr;
   logic [EW-1:0] wdata, rdata, new_entry;

   // current beat fields
   logic [47:0]              d_time, d_addr;
   logic [CHANNEL_WIDTH-1:0] d_ch;
   logic                     d_data;
   logic [15:0]              d_tag, d_bytes;
   logic                     xp, sel, crit, rm, ev, cnt, is_ins, issue;
   logic [CMPW-1:0]          live_w;
   logic [CW+9:0]            cnt_ext, rem_ext;

   assign d_bytes = rdata[15:0];
   assign d_tag   = rdata[T_LO +: 16];
   assign d_data  = rdata[D_AT];
   assign d_ch    = rdata[C_LO +: CHANNEL_WIDTH];
   assign d_addr  = rdata[A_LO +: 48];
   assign d_time  = rdata[M_LO +: 48];

   assign new_entry = {now_ff, addr_ff, ch_ff, data_ff, tag_ff, bytes_ff};
   assign is_ins    = (op_ff inside {OP_ENQ, OP_PUSH});
   assign xp        = ({1'b0, now_ff} > ({1'b0, d_time} + 49'(max_delay)));

   assign issue  = (iss_ff < len_ff);
   assign rd_idx = (kind_ff == PASS_SHIFT) ? (len_ff - iss_ff - CW'(1)) : iss_ff;
   assign raddr  = rd_idx[IW-1:0];

   assign live_w         = CMPW'(live_ff);
   assign sts.full       = (live_w >= CMPW'(QUEUE_DEPTH)) || (live_w >= CMPW'(max_packets));
   assign sts.pass_busy  = issue | v1_ff;
   assign sts.hit_valid  = found_ff | (is_ins & evict_oldest & (live_ff != '0));

   always_comb begin
      sel = 1'b0;
      case (op_ff)
         OP_DEQ_ADDR:  sel = (d_addr == addr_ff);
         OP_DEQ_CHAN:  sel = (d_ch == ch_ff);
         OP_DEQ_BOTH:  sel = (d_addr == addr_ff) && (d_ch == ch_ff);
         OP_DEQ_NCHAN: sel = (d_ch != ch_ff);
         default:      sel = 1'b0;
      endcase
      sel  = sel & d_data;
      crit = is_ins ? xp : (!xp && sel);

      rm  = 1'b0;
      ev  = 1'b0;
      cnt = 1'b0;
      case (op_ff) inside
         OP_ENQ, OP_PUSH: rm = (idx1_ff == hit_ff);
         OP_DEQ_HEAD: begin
            rm = !done_ff;
            ev = !done_ff && !xp;
         end
         [OP_DEQ_ADDR:OP_DEQ_NCHAN]: begin
            ev = (idx1_ff == hit_ff);
            rm = ev || ((idx1_ff < hit_ff) && xp);
         end
         OP_COUNT, OP_PURGE: begin
            rm  = xp;
            cnt = !xp && d_data && (d_addr == addr_ff);
         end
         OP_FIND, OP_REMOVE: begin
            ev = !done_ff && !xp &&
                 ((op_ff == OP_FIND) ? (d_ch == ch_ff) : (d_tag == tag_ff));
            rm = !done_ff && (xp || (ev && (op_ff == OP_REMOVE)));
         end
         default: rm = 1'b0;
      endcase

      we    = 1'b0;
      waddr = w_ff[IW-1:0];
      wdata = rdata;
      if (cmd.write_new) begin
         we    = 1'b1;
         waddr = (op_ff == OP_PUSH) ? '0 : live_ff[IW-1:0];
         wdata = new_entry;
      end else if (v1_ff && kind_ff == PASS_SHIFT) begin
         we    = 1'b1;
         waddr = idx1_ff + IW'(1);
      end else if (v1_ff && kind_ff == PASS_COMPACT) begin
         we = !rm;
      end
   end

   ttlpq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         now_ff   <= req_now_time;
         addr_ff  <= req_dest_addr;
         ch_ff    <= req_channel_id;
         data_ff  <= req_is_data;
         tag_ff   <= req_packet_tag;
         bytes_ff <= req_packet_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         len_ff   <= '0;
         iss_ff   <= '0;
         v1_ff    <= 1'b0;
         kind_ff  <= PASS_SEARCH;
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         v1_ff   <= issue;
         idx1_ff <= rd_idx[IW-1:0];
         if (issue) begin
            iss_ff <= iss_ff + CW'(1);
         end
         if (cmd.load) begin
            found_ff     <= 1'b0;
            done_ff      <= 1'b0;
            hit_ff       <= '0;
            removed_ff   <= '0;
            count_ff     <= '0;
            rep_tag_ff   <= '0;
            rep_addr_ff  <= '0;
            rep_ch_ff    <= '0;
            rep_bytes_ff <= '0;
         end
         if (cmd.pass_start) begin
            kind_ff <= cmd.pass_kind;
            len_ff  <= live_ff;
            iss_ff  <= '0;
            w_ff    <= '0;
         end
         if (v1_ff && kind_ff == PASS_SEARCH && !found_ff && crit) begin
            found_ff <= 1'b1;
            hit_ff   <= idx1_ff;
         end
         if (v1_ff && kind_ff == PASS_COMPACT) begin
            if (rm) begin
               live_ff <= live_ff - CW'(1);
               if (xp) removed_ff <= removed_ff + CW'(1);
            end else begin
               w_ff <= w_ff + CW'(1);
            end
            if (cnt) count_ff <= count_ff + CW'(1);
            if (ev) begin
               done_ff <= 1'b1;
               // find reports no entry
               if (op_ff != OP_FIND) begin
                  rep_tag_ff   <= d_tag;
                  rep_addr_ff  <= d_addr;
                  rep_ch_ff    <= d_ch;
                  rep_bytes_ff <= d_bytes;
               end
            end
         end
         if (cmd.write_new) begin
            live_ff <= live_ff + CW'(1);
         end
         if (cmd.finish) begin
            case (op_ff) inside
               OP_ENQ, OP_PUSH:     status_ff <= cmd.drop ? ST_DROP : ST_OK;
               OP_COUNT, OP_PURGE:  status_ff <= ST_OK;
               [OP_DEQ_HEAD:OP_DEQ_NCHAN], OP_FIND, OP_REMOVE:
                  status_ff <= done_ff ? ST_OK : ST_MISS;
               default:             status_ff <= ST_MISS;
            endcase
         end
      end
   end

   assign cnt_ext = {10'b0, (op_ff == OP_COUNT) ? count_ff : live_ff};
   assign rem_ext = {10'b0, removed_ff};

   assign rsp_status          = status_ff;
   assign rsp_out_tag         = rep_tag_ff;
   assign rsp_out_addr        = rep_addr_ff;
   assign rsp_out_channel     = rep_ch_ff;
   assign rsp_out_bytes       = rep_bytes_ff;
   assign rsp_out_count       = cnt_ext[OUT_CNT_W-1:0];
   assign rsp_expired_removed = rem_ext[OUT_CNT_W-1:0];

endmodule

// ===== src/ttl_packet_queue_selective_dequeue.sv =====
// Ordered descriptor queue with lifetime expiry and selective dequeue.
//
// Commands arrive on the req_ channel (valid/stall); each one yields exactly
// one result beat on the rsp_ channel. One command is handled at a time:
// req_stall stays high from acceptance until its result beat is taken, and
// the next command can be taken in the cycle after that.
// Entries live in one RAM in queue order; commands walk it with scan
// passes that read one entry per cycle and write back kept entries
// compacted, or shift entries up for an insert at the head.
// Passes per command: none for an unused opcode or for an insert into a
// non-full queue at the tail, one compact pass for dequeue head, count,
// purge, find and remove by tag, a shift pass for a push front when not
// full, a search and then a compact pass for a selective dequeue that
// hits, and up to search, evict and shift for a push front into a full
// queue. Each pass reads every live entry of the one-read, one-write RAM.
// Reset empties the queue and loads the register defaults; entry contents
// are not cleared. csr_ writes take effect at once and belong between
// commands. When rsp_stall is high the result holds and no new command is
// taken.
module ttl_packet_queue_selective_dequeue #(
   parameter int QUEUE_DEPTH   = 512,
   parameter int CHANNEL_WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [3:0]               req_opcode,
   input  logic [47:0]              req_now_time,
   input  logic [47:0]              req_dest_addr,
   input  logic [CHANNEL_WIDTH-1:0] req_channel_id,
   input  logic                     req_is_data,
   input  logic [15:0]              req_packet_tag,
   input  logic [15:0]              req_packet_bytes,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [15:0]              rsp_out_tag,
   output logic [47:0]              rsp_out_addr,
   output logic [CHANNEL_WIDTH-1:0] rsp_out_channel,
   output logic [15:0]              rsp_out_bytes,
   output logic [9:0]               rsp_out_count,
   output logic [9:0]               rsp_expired_removed,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata
);
   import ttlpq_pkg::*;

   logic [31:0] max_delay_ff;
   logic        evict_oldest_ff;
   logic [9:0]  max_packets_ff;
   cmd_type     cmd;
   sts_type     sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff    <= 32'd500000;
         evict_oldest_ff <= 1'b0;
         max_packets_ff  <= 10'd500;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_DELAY:    max_delay_ff    <= csr_wdata;
            CSR_EVICT_OLDEST: evict_oldest_ff <= csr_wdata[0];
            CSR_MAX_PACKETS:  max_packets_ff  <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   ttlpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   ttlpq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .CHANNEL_WIDTH(CHANNEL_WIDTH)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .max_delay           (max_delay_ff),
      .evict_oldest        (evict_oldest_ff),
      .max_packets         (max_packets_ff),
      .req_opcode          (req_opcode),
      .req_now_time        (req_now_time),
      .req_dest_addr       (req_dest_addr),
      .req_channel_id      (req_channel_id),
      .req_is_data         (req_is_data),
      .req_packet_tag      (req_packet_tag),
      .req_packet_bytes    (req_packet_bytes),
      .rsp_status          (rsp_status),
      .rsp_out_tag         (rsp_out_tag),
      .rsp_out_addr        (rsp_out_addr),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_out_bytes       (rsp_out_bytes),
      .rsp_out_count       (rsp_out_count),
      .rsp_expired_removed (rsp_expired_removed)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result beat shown while a new command can be taken");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !req_stall)
      else $error("block not ready after result beat was taken");

   a_drop_no_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DROP) |-> (rsp_out_tag == '0 && rsp_out_bytes == '0))
      else $error("dropped insert reports an entry");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_MISS || rsp_status == ST_DROP))
      else $error("undefined status code");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the expiring descriptor queue with selective dequeue.
`timescale 1ns / 100ps

module tb_top;
   import ttlpq_pkg::*;

   typedef struct packed {
      logic [3:0]  op;
      logic [47:0] now;
      logic [47:0] addr;
      logic [7:0]  ch;
      logic        dat;
      logic [15:0] tag;
      logic [15:0] bytes;
   } item_type;

   typedef struct packed {
      logic [47:0] stamp;
      logic [47:0] addr;
      logic [7:0]  ch;
      logic        dat;
      logic [15:0] tag;
      logic [15:0] bytes;
   } desc_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] tag;
      logic [47:0] addr;
      logic [7:0]  ch;
      logic [15:0] bytes;
      logic [9:0]  count;
      logic [9:0]  removed;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_opcode = '0;
   logic [47:0] req_now_time = '0;
   logic [47:0] req_dest_addr = '0;
   logic [7:0] req_channel_id = '0;
   logic req_is_data = 1'b0;
   logic [15:0] req_packet_tag = '0;
   logic [15:0] req_packet_bytes = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [15:0] rsp_out_tag;
   logic [47:0] rsp_out_addr;
   logic [7:0] rsp_out_channel;
   logic [15:0] rsp_out_bytes;
   logic [9:0] rsp_out_count;
   logic [9:0] rsp_expired_removed;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   ttl_packet_queue_selective_dequeue u_top (.*);

   always #10 clock = ~clock;

   // Shadow of the queue contents and registers
   desc_type    held_q[$];
   logic [31:0] life_ticks = 32'd500000;
   logic        evict_head = 1'b0;
   logic [9:0]  capacity = 10'd500;

   result_type  pending_q[$];
   int          fail_cnt = 0;
   int          burst_left = 0;
   logic [47:0] tick = '0;
   bit          long_hold = 1'b0;
   logic [47:0] addr_pool[4] = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0000_1234_5678,
                                 48'hA5A5_0F0F_C3C3};

   function automatic bit aged(int i, logic [47:0] now);
      return {16'b0, now} > {16'b0, held_q[i].stamp} + {32'b0, life_ticks};
   endfunction

   function automatic bit picks(int i, item_type c);
      if (!held_q[i].dat) return 1'b0;
      case (c.op)
         OP_DEQ_ADDR: return held_q[i].addr == c.addr;
         OP_DEQ_CHAN: return held_q[i].ch == c.ch;
         OP_DEQ_BOTH: return held_q[i].addr == c.addr && held_q[i].ch == c.ch;
         default:     return held_q[i].ch != c.ch;
      endcase
   endfunction

   function automatic result_type queue_step(item_type c);
      result_type r;
      desc_type d;
      int i, k, cap, hits, removed;
      r = '0;
      r.status = ST_MISS;
      hits = 0;
      removed = 0;
      cap = (capacity > 10'd512) ? 512 : int'(capacity);
      case (c.op)
         OP_ENQ, OP_PUSH: begin
            if (held_q.size() >= cap) begin
               for (i = 0; i < held_q.size(); i++)
                  if (aged(i, c.now)) break;
               if (i < held_q.size()) begin
                  held_q.delete(i);
                  removed = 1;
               end else if (evict_head && held_q.size() > 0) begin
                  held_q.delete(0);
               end
            end
            if (held_q.size() < cap) begin
               d = '{c.now, c.addr, c.ch, c.dat, c.tag, c.bytes};
               if (c.op == OP_ENQ) held_q.insert(held_q.size(), d);
               else held_q.push_front(d);
               r.status = ST_OK;
            end else begin
               r.status = ST_DROP;
            end
         end
         OP_DEQ_HEAD: begin
            while (held_q.size() > 0 && aged(0, c.now)) begin
               held_q.delete(0);
               removed++;
            end
            if (held_q.size() > 0) begin
               d = held_q.pop_front();
               {r.tag, r.addr, r.ch, r.bytes} = {d.tag, d.addr, d.ch, d.bytes};
               r.status = ST_OK;
            end
         end
         OP_DEQ_ADDR, OP_DEQ_CHAN, OP_DEQ_BOTH, OP_DEQ_NCHAN: begin
            for (i = 0; i < held_q.size(); i++)
               if (!aged(i, c.now) && picks(i, c)) break;
            if (i < held_q.size()) begin
               k = 0;
               while (k < i) begin
                  if (aged(k, c.now)) begin
                     held_q.delete(k);
                     i--;
                     removed++;
                  end else begin
                     k++;
                  end
               end
               d = held_q[i];
               held_q.delete(i);
               {r.tag, r.addr, r.ch, r.bytes} = {d.tag, d.addr, d.ch, d.bytes};
               r.status = ST_OK;
            end
         end
         OP_COUNT, OP_PURGE: begin
            i = 0;
            while (i < held_q.size()) begin
               if (aged(i, c.now)) begin
                  held_q.delete(i);
                  removed++;
               end else begin
                  if (held_q[i].dat && held_q[i].addr == c.addr) hits++;
                  i++;
               end
            end
            r.status = ST_OK;
         end
         OP_FIND, OP_REMOVE: begin
            i = 0;
            while (i < held_q.size()) begin
               if (aged(i, c.now)) begin
                  held_q.delete(i);
                  removed++;
               end else if ((c.op == OP_FIND) ? (held_q[i].ch == c.ch)
                                              : (held_q[i].tag == c.tag)) begin
                  break;
               end else begin
                  i++;
               end
            end
            if (i < held_q.size()) begin
               r.status = ST_OK;
               if (c.op == OP_REMOVE) begin
                  d = held_q[i];
                  held_q.delete(i);
                  {r.tag, r.addr, r.ch, r.bytes} = {d.tag, d.addr, d.ch, d.bytes};
               end
            end
         end
         default: ;
      endcase
      r.count = 10'((c.op == OP_COUNT) ? hits : held_q.size());
      r.removed = 10'(removed);
      return r;
   endfunction

   function automatic item_type mk(logic [3:0] op, logic [47:0] now, logic [47:0] addr,
                                   logic [7:0] ch, logic dat, logic [15:0] tag,
                                   logic [15:0] bytes);
      return '{op, now, addr, ch, dat, tag, bytes};
   endfunction

   function automatic item_type rand_cmd();
      item_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) c.op = OP_ENQ;
      else if (pick < 40) c.op = OP_PUSH;
      else if (pick < 98) c.op = 4'($urandom_range(OP_DEQ_HEAD, OP_PURGE));
      else c.op = 4'($urandom_range(11, 15));
      if ($urandom_range(0, 99) < 3) begin
         c.now = 48'({$urandom, $urandom});
      end else begin
         tick = tick + 48'($urandom_range(0, 30));
         c.now = tick;
      end
      if ($urandom_range(0, 9) == 0) c.addr = 48'({$urandom, $urandom});
      else c.addr = addr_pool[$urandom_range(0, 3)];
      c.ch = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      c.dat = ($urandom_range(0, 3) != 0);
      c.tag = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 7)) : 16'($urandom);
      c.bytes = 16'($urandom);
      return c;
   endfunction

   // Drive one command beat in bursts with random gaps; predict on acceptance
   task automatic send_cmd(item_type c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= c.op;
      req_now_time <= c.now;
      req_dest_addr <= c.addr;
      req_channel_id <= c.ch;
      req_is_data <= c.dat;
      req_packet_tag <= c.tag;
      req_packet_bytes <= c.bytes;
      do @(posedge clock); while (req_stall);
      pending_q.insert(pending_q.size(), queue_step(c));
   endtask

   task automatic send_random(int n);
      repeat (n) send_cmd(rand_cmd());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      wait (pending_q.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MAX_DELAY:    life_ticks = val;
         CSR_EVICT_OLDEST: evict_head = val[0];
         CSR_MAX_PACKETS:  capacity = val[9:0];
         default: ;
      endcase
   endtask

   task automatic test_directed();
      logic [47:0] ones;
      ones = 48'hFFFF_FFFF_FFFF;
      send_cmd(mk(OP_DEQ_HEAD, 0, 0, 0, 0, 0, 0));
      send_cmd(mk(OP_COUNT, 1, 0, 0, 0, 0, 0));
      send_cmd(mk(OP_ENQ, 10, ones, 8'hFF, 1, 16'hFFFF, 16'hFFFF));
      send_cmd(mk(OP_ENQ, 11, 0, 0, 1, 0, 0));
      send_cmd(mk(OP_PUSH, 12, 48'h1234, 7, 0, 5, 100));
      send_cmd(mk(OP_ENQ, 13, 48'hABCD, 3, 1, 9, 64));
      send_cmd(mk(OP_ENQ, 13, 48'hABCD, 1, 1, 10, 65));
      send_cmd(mk(OP_DEQ_ADDR, 14, ones, 0, 0, 0, 0));
      send_cmd(mk(OP_DEQ_CHAN, 15, 0, 0, 0, 0, 0));
      send_cmd(mk(OP_DEQ_BOTH, 16, 48'hABCD, 3, 0, 0, 0));
      send_cmd(mk(OP_DEQ_NCHAN, 17, 0, 1, 0, 0, 0));
      send_cmd(mk(OP_DEQ_NCHAN, 17, 0, 7, 0, 0, 0));
      send_cmd(mk(OP_FIND, 18, 0, 7, 0, 0, 0));
      send_cmd(mk(OP_FIND, 18, 0, 9, 0, 0, 0));
      send_cmd(mk(OP_REMOVE, 19, 0, 0, 0, 5, 0));
      send_cmd(mk(OP_REMOVE, 19, 0, 0, 0, 5, 0));
      send_cmd(mk(OP_ENQ, 20, 48'h55, 2, 1, 1, 1));
      send_cmd(mk(OP_ENQ, 21, 48'h55, 2, 1, 2, 2));
      send_cmd(mk(OP_COUNT, 22, 48'h55, 0, 0, 0, 0));
      send_cmd(mk(OP_DEQ_ADDR, 23, 48'h77, 0, 0, 0, 0));
      send_cmd(mk(4'd11, 24, 0, 0, 0, 0, 0));
      send_cmd(mk(4'd15, 24, ones, 8'hFF, 1, 16'hFFFF, 16'hFFFF));
      // Far future: everything stored has expired
      send_cmd(mk(OP_PURGE, ones, 0, 0, 0, 0, 0));
      send_cmd(mk(OP_ENQ, ones, 48'h1, 1, 1, 3, 3));
      send_cmd(mk(OP_DEQ_HEAD, 0, 0, 0, 0, 0, 0));
      drain();
   endtask

   task automatic test_config();
      csr_write(CSR_MAX_DELAY, 32'd0);
      send_random(30);
      drain();
      csr_write(CSR_MAX_DELAY, 32'hFFFF_FFFF);
      csr_write(CSR_EVICT_OLDEST, 32'd1);
      csr_write(CSR_MAX_PACKETS, 32'd3);
      send_random(40);
      drain();
      csr_write(CSR_MAX_DELAY, 32'd50);
      send_random(40);
      drain();
      csr_write(CSR_EVICT_OLDEST, 32'd0);
      csr_write(CSR_MAX_PACKETS, 32'd0);
      repeat (8) send_cmd(mk(4'($urandom_range(0, 1)), tick, 48'h9, 1, 1, 4, 4));
      drain();
      csr_write(CSR_MAX_PACKETS, 32'd1023);
      send_random(30);
      drain();
      // Fill, then shrink the capacity below the live count
      csr_write(CSR_MAX_DELAY, 32'd100000);
      csr_write(CSR_MAX_PACKETS, 32'd20);
      repeat (15) send_cmd(mk(OP_ENQ, tick, addr_pool[$urandom_range(0, 3)],
                              8'($urandom_range(0, 3)), 1, 16'($urandom_range(0, 7)),
                              16'($urandom)));
      drain();
      csr_write(CSR_MAX_PACKETS, 32'd4);
      csr_write(CSR_EVICT_OLDEST, $urandom_range(0, 1));
      send_random(20);
      drain();
   endtask

   task automatic test_random();
      int caps[5] = '{2, 5, 8, 16, 64};
      foreach (caps[i]) begin
         csr_write(CSR_MAX_DELAY, $urandom_range(20, 400));
         csr_write(CSR_EVICT_OLDEST, $urandom_range(0, 1));
         csr_write(CSR_MAX_PACKETS, caps[i]);
         send_random(65);
         drain();
      end
   endtask

   task automatic test_pressure();
      csr_write(CSR_MAX_DELAY, 32'd1000);
      long_hold = 1'b1;
      send_random(15);
      drain();
   endtask

   // Result-side stall pattern, with one long hold on request
   initial begin
      int mode, left;
      left = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(20, 150);
            end
            left--;
            rsp_stall <= (mode == 0) ? 1'b0 :
                         (mode == 1) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
         end
      end
   end

   task automatic chk(string nm, logic [47:0] e, logic [47:0] a);
      if (e !== a) begin
         $error("%s expected %0h got %0h", nm, e, a);
         fail_cnt++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_cnt++;
         end else begin
            e = pending_q.pop_front();
            chk("status", 48'(e.status), 48'(rsp_status));
            chk("out_tag", 48'(e.tag), 48'(rsp_out_tag));
            chk("out_addr", e.addr, rsp_out_addr);
            chk("out_channel", 48'(e.ch), 48'(rsp_out_channel));
            chk("out_bytes", 48'(e.bytes), 48'(rsp_out_bytes));
            chk("out_count", 48'(e.count), 48'(rsp_out_count));
            chk("expired_removed", 48'(e.removed), 48'(rsp_expired_removed));
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config();
      test_random();
      test_pressure();
      drain();
      repeat (20) @(posedge clock);
      if (fail_cnt == 0 && pending_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ttlpq_pkg.sv
src/ttlpq_ram.sv
src/ttlpq_ctrl.sv
src/ttlpq_dp.sv
src/ttl_packet_queue_selective_dequeue.sv
dv/tb_top.sv
